@@ rtl/hpq_pkg.sv @@
// Shared types, constants and command/status structures for the sorted priority queue.
package hpq_pkg;

  localparam int unsigned DEPTH_DEF        = 128;
  localparam int unsigned WEIGHT_WIDTH_DEF = 32;
  localparam int unsigned SYM_W            = 8;
  localparam int unsigned IN_WEIGHT_W      = 32;
  localparam int unsigned OCC_W            = 8;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_LAST,
    RD_PREV
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_ITEM_NEXT,
    WR_ITEM_HEAD
  } wr_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP_WAIT,
    ST_HEAD_CHK,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic   capture;
    rd_op_t rd_op;
    wr_op_t wr_op;
    logic   pop_take;
    logic   set_ovf;
    logic   load_out;
  } hpq_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic w_zero;
    logic empty;
    logic full;
    logic idx_zero;
    logic rd_ge;
    logic rd_gt;
    logic out_free;
  } hpq_stat_t;

endpackage

@@ rtl/hpq_if.sv @@
// Valid/ready channel interfaces for the queue's input and result transactions.
interface hpq_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  symbol;
  logic [31:0] weight;

  modport source (output valid, output kind, output symbol, output weight, input ready);
  modport sink (input valid, input kind, input symbol, input weight, output ready);
endinterface

interface hpq_out_if;
  logic        valid;
  logic        ready;
  logic        popped_valid;
  logic [7:0]  popped_symbol;
  logic [31:0] popped_weight;
  logic [7:0]  occupancy;
  logic        overflow;

  modport source (
    output valid, output popped_valid, output popped_symbol, output popped_weight,
    output occupancy, output overflow, input ready
  );
  modport sink (
    input valid, input popped_valid, input popped_symbol, input popped_weight,
    input occupancy, input overflow, output ready
  );
endinterface

@@ rtl/hpq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module hpq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/hpq_datapath.sv @@
// Datapath: circular entry store, item and result registers, and the output register.
module hpq_datapath #(
  parameter int unsigned DEPTH        = hpq_pkg::DEPTH_DEF,
  parameter int unsigned WEIGHT_WIDTH = hpq_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpq_pkg::hpq_cmd_t                cmd,
  output hpq_pkg::hpq_stat_t               stat,
  input  logic                             in_kind,
  input  logic [hpq_pkg::SYM_W-1:0]        in_symbol,
  input  logic [hpq_pkg::IN_WEIGHT_W-1:0]  in_weight,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_popped_valid,
  output logic [hpq_pkg::SYM_W-1:0]        out_popped_symbol,
  output logic [hpq_pkg::IN_WEIGHT_W-1:0]  out_popped_weight,
  output logic [hpq_pkg::OCC_W-1:0]        out_occupancy,
  output logic                             out_overflow
);
  import hpq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = SYM_W + WEIGHT_WIDTH;
  localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                            input logic [AW-1:0] lidx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, lidx};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    kind_r;
  logic [SYM_W-1:0]        sym_r;
  logic [WEIGHT_WIDTH-1:0] w_r;
  logic                    res_valid_r;
  logic [SYM_W-1:0]        res_sym_r;
  logic [WEIGHT_WIDTH-1:0] res_w_r;
  logic                    res_ovf_r;
  logic                    out_pv_r;
  logic [SYM_W-1:0]        out_sym_r;
  logic [IN_WEIGHT_W-1:0]  out_w_r;
  logic [OCC_W-1:0]        out_occ_r;
  logic                    out_ovf_r;

  logic [AW-1:0]           head_dec, head_inc, last_idx, prev_idx, next_idx;
  logic                    rd_en, wr_en, wr_item;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [EW-1:0]           wr_data, rd_data;
  logic [WEIGHT_WIDTH-1:0] rd_w;
  logic [SYM_W-1:0]        rd_sym;

  assign head_dec = (head_r == '0) ? LAST_ADDR : head_r - AW'(1);
  assign head_inc = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
  assign last_idx = AW'(count_r - CW'(1));
  assign prev_idx = idx_r - AW'(1);
  assign next_idx = idx_r + AW'(1);
  assign rd_w     = rd_data[WEIGHT_WIDTH-1:0];
  assign rd_sym   = rd_data[EW-1 -: SYM_W];
  assign rd_en    = (cmd.rd_op != RD_NONE);
  assign wr_en    = (cmd.wr_op != WR_NONE);
  assign wr_item  = (cmd.wr_op == WR_ITEM_NEXT) || (cmd.wr_op == WR_ITEM_HEAD);

  always_comb begin
    unique case (cmd.rd_op)
      RD_HEAD: rd_addr = head_r;
      RD_LAST: rd_addr = to_phys(head_r, last_idx);
      RD_PREV: rd_addr = to_phys(head_r, prev_idx);
      RD_NONE: rd_addr = head_r;
      default: rd_addr = head_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_op)
      WR_SHIFT: begin
        wr_addr = to_phys(head_r, next_idx);
        wr_data = rd_data;
      end
      WR_ITEM_NEXT: begin
        wr_addr = to_phys(head_r, next_idx);
        wr_data = {sym_r, w_r};
      end
      WR_ITEM_HEAD: begin
        wr_addr = head_dec;
        wr_data = {sym_r, w_r};
      end
      WR_NONE: begin
        wr_addr = head_r;
        wr_data = {sym_r, w_r};
      end
      default: begin
        wr_addr = head_r;
        wr_data = {sym_r, w_r};
      end
    endcase
  end

  hpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    if (wr_item) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_take) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.wr_op == WR_ITEM_HEAD) begin
      head_nxt = head_dec;
    end else if (cmd.pop_take) begin
      head_nxt = head_inc;
    end
    if (cmd.rd_op == RD_LAST) begin
      idx_nxt = last_idx;
    end else if (cmd.rd_op == RD_PREV) begin
      idx_nxt = prev_idx;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r      <= in_kind;
      sym_r       <= in_symbol;
      w_r         <= WEIGHT_WIDTH'(in_weight);
      res_valid_r <= 1'b0;
      res_sym_r   <= '0;
      res_w_r     <= '0;
      res_ovf_r   <= 1'b0;
    end else begin
      if (cmd.pop_take) begin
        res_valid_r <= 1'b1;
        res_sym_r   <= rd_sym;
        res_w_r     <= rd_w;
      end
      if (cmd.set_ovf) begin
        res_ovf_r <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_pv_r  <= res_valid_r;
      out_sym_r <= res_sym_r;
      out_w_r   <= IN_WEIGHT_W'(res_w_r);
      out_occ_r <= OCC_W'(count_r);
      out_ovf_r <= res_ovf_r;
    end
  end

  assign stat.is_pop   = kind_r;
  assign stat.w_zero   = (w_r == '0);
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == FULL_CNT);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.rd_ge    = (rd_w >= w_r);
  assign stat.rd_gt    = (rd_w > w_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_popped_valid  = out_pv_r;
  assign out_popped_symbol = out_sym_r;
  assign out_popped_weight = out_w_r;
  assign out_occupancy     = out_occ_r;
  assign out_overflow      = out_ovf_r;

endmodule

@@ rtl/hpq_controller.sv @@
// Controller state machine that sequences inserts, pops and result hand-off.
module hpq_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hpq_pkg::hpq_stat_t  stat,
  output hpq_pkg::hpq_cmd_t   cmd
);
  import hpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.rd_op    = RD_NONE;
    cmd.wr_op    = WR_NONE;
    cmd.pop_take = 1'b0;
    cmd.set_ovf  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_pop) begin
          if (stat.empty) begin
            state_nxt = ST_RESP;
          end else begin
            cmd.rd_op = RD_HEAD;
            state_nxt = ST_POP_WAIT;
          end
        end else if (stat.w_zero) begin
          state_nxt = ST_RESP;
        end else if (stat.full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = ST_RESP;
        end else if (stat.empty) begin
          cmd.wr_op = WR_ITEM_HEAD;
          state_nxt = ST_RESP;
        end else begin
          cmd.rd_op = RD_HEAD;
          state_nxt = ST_HEAD_CHK;
        end
      end
      ST_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_HEAD_CHK: begin
        if (stat.rd_gt) begin
          cmd.wr_op = WR_ITEM_HEAD;
          state_nxt = ST_RESP;
        end else begin
          cmd.rd_op = RD_LAST;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.idx_zero) begin
          cmd.wr_op = WR_ITEM_NEXT;
          state_nxt = ST_RESP;
        end else if (stat.rd_ge) begin
          cmd.wr_op = WR_SHIFT;
          cmd.rd_op = RD_PREV;
        end else begin
          cmd.wr_op = WR_ITEM_NEXT;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/huffman_sorted_priority_queue_top.sv @@
// Top level of the sorted-list priority queue; reset (synchronous, active low) empties the list.
// Sequence: a skipped, dropped or first insert, or a pop of an empty list, goes from dispatch
// straight to the response state that loads the output register; a pop first reads the head, an
// insert in front of the head first checks the head, and any other insert into n entries then
// walks back from the tail one entry per cycle. One transaction is handled at a time; the next is
// accepted in the cycle after the previous result is loaded, and a stalled output delays that load.
module huffman_sorted_priority_queue_top #(
  parameter int unsigned DEPTH        = hpq_pkg::DEPTH_DEF,
  parameter int unsigned WEIGHT_WIDTH = hpq_pkg::WEIGHT_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  hpq_in_if.sink   in_if,
  hpq_out_if.source out_if
);
  import hpq_pkg::*;

  hpq_cmd_t  cmd;
  hpq_stat_t stat;
  logic      in_ready;

  assign in_if.ready = in_ready;

  hpq_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpq_datapath #(
    .DEPTH        (DEPTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_if.kind),
    .in_symbol         (in_if.symbol),
    .in_weight         (in_if.weight),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_popped_valid  (out_if.popped_valid),
    .out_popped_symbol (out_if.popped_symbol),
    .out_popped_weight (out_if.popped_weight),
    .out_occupancy     (out_if.occupancy),
    .out_overflow      (out_if.overflow)
  );

`ifndef SYNTHESIS
  a_load_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("Result loaded while the output register still held a transaction.");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_op == WR_ITEM_NEXT || cmd.wr_op == WR_ITEM_HEAD) |-> !stat.full)
    else $error("Entry written into a full list.");

  a_capture_on_handshake: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (in_if.valid && in_if.ready))
    else $error("Item captured without an input transaction.");

  a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_if.ready)
    else $error("Input accepted again while an item was still in progress.");

  a_overflow_excludes_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.overflow) |-> !out_if.popped_valid)
    else $error("Result reports both an overflow and a popped entry.");
`endif

endmodule

@@ sim/huffman_sorted_priority_queue_top_tb.sv @@
// Self-checking testbench for the sorted-list priority queue with driver and scoreboard.
`timescale 1ns / 100ps

module huffman_sorted_priority_queue_top_tb;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;
  localparam int   LIST_DEPTH  = hpq_pkg::DEPTH_DEF;
  localparam int   IDLE_PCT    = 17;
  localparam int   CALM_FIRST  = 300;
  localparam int   CALM_LAST   = 500;
  localparam int   DRAIN_CYCLES = 150;

  typedef struct packed {
    logic                            kind;
    logic [hpq_pkg::SYM_W-1:0]       symbol;
    logic [hpq_pkg::IN_WEIGHT_W-1:0] weight;
  } queue_cmd_t;

  typedef struct packed {
    logic                            popped_valid;
    logic [hpq_pkg::SYM_W-1:0]       popped_symbol;
    logic [hpq_pkg::IN_WEIGHT_W-1:0] popped_weight;
    logic [hpq_pkg::OCC_W-1:0]       occupancy;
    logic                            overflow;
  } queue_result_t;

  logic clk;
  logic rst_n;

  hpq_in_if  in_ch ();
  hpq_out_if out_ch ();

  huffman_sorted_priority_queue_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];
  queue_cmd_t    next_cmd;
  queue_result_t got_result;
  queue_result_t want_result;

  logic [hpq_pkg::IN_WEIGHT_W-1:0] list_weight [LIST_DEPTH];
  logic [hpq_pkg::SYM_W-1:0]       list_tag    [LIST_DEPTH];
  int                              list_count;

  int error_count;
  int accepted_count;
  int result_count;

  wire calm_in  = (accepted_count >= CALM_FIRST) && (accepted_count < CALM_LAST);
  wire calm_out = (result_count >= CALM_FIRST) && (result_count < CALM_LAST);

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      report_mismatch($sformatf("result %0d %s expected %0h got %0h", result_count, name, want,
                                got));
    end
  endtask

  task automatic predict_result(input queue_cmd_t cmd);
    queue_result_t r;
    int            slot;
    r = '0;
    if (cmd.kind == KIND_POP) begin
      if (list_count > 0) begin
        r.popped_valid  = 1'b1;
        r.popped_symbol = list_tag[0];
        r.popped_weight = list_weight[0];
        for (int i = 1; i < list_count; i++) begin
          list_weight[i-1] = list_weight[i];
          list_tag[i-1]    = list_tag[i];
        end
        list_count--;
      end
    end else if (cmd.weight != '0) begin
      if (list_count >= LIST_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        if (list_count == 0 || cmd.weight < list_weight[0]) begin
          slot = 0;
        end else begin
          slot = list_count;
          for (int i = list_count - 1; i >= 1; i--) begin
            if (list_weight[i] >= cmd.weight) slot = i;
          end
        end
        for (int i = list_count; i > slot; i--) begin
          list_weight[i] = list_weight[i-1];
          list_tag[i]    = list_tag[i-1];
        end
        list_weight[slot] = cmd.weight;
        list_tag[slot]    = cmd.symbol;
        list_count++;
      end
    end
    r.occupancy = list_count[hpq_pkg::OCC_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic queue_cmd(input logic kind, input logic [7:0] symbol, input logic [31:0] weight);
    queue_cmd_t c;
    c.kind   = kind;
    c.symbol = symbol;
    c.weight = weight;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 50) return $urandom_range(16, 1);
    if (r < 60) return 32'h1 << $urandom_range(31);
    return $urandom;
  endfunction

  task automatic queue_random_phase(input int count, input int insert_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < insert_pct) begin
        queue_cmd(KIND_INSERT, 8'($urandom_range(255)), pick_weight());
      end else begin
        queue_cmd(KIND_POP, 8'($urandom_range(255)), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_result('{kind: in_ch.kind, symbol: in_ch.symbol, weight: in_ch.weight});
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && (calm_in || $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = pending_cmds.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.kind   <= next_cmd.kind;
          in_ch.symbol <= next_cmd.symbol;
          in_ch.weight <= next_cmd.weight;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_result = '{popped_valid: out_ch.popped_valid, popped_symbol: out_ch.popped_symbol,
                       popped_weight: out_ch.popped_weight, occupancy: out_ch.occupancy,
                       overflow: out_ch.overflow};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                    result_count));
        end else begin
          want_result = expected_results.pop_front();
          check_field("popped_valid", 32'(want_result.popped_valid),
                      32'(got_result.popped_valid));
          check_field("popped_symbol", 32'(want_result.popped_symbol),
                      32'(got_result.popped_symbol));
          check_field("popped_weight", want_result.popped_weight, got_result.popped_weight);
          check_field("occupancy", 32'(want_result.occupancy), 32'(got_result.occupancy));
          check_field("overflow", 32'(want_result.overflow), 32'(got_result.overflow));
        end
        result_count++;
      end
      out_ch.ready <= calm_out || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_INSERT;
    in_ch.symbol   = '0;
    in_ch.weight   = '0;
    out_ch.ready   = 1'b0;
    list_count     = 0;
    error_count    = 0;
    accepted_count = 0;
    result_count   = 0;

    queue_cmd(KIND_POP, 8'h00, 32'h0000_0000);
    queue_cmd(KIND_INSERT, 8'h5A, 32'h0000_0000);
    queue_cmd(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
    queue_cmd(KIND_INSERT, 8'h00, 32'h0000_0001);
    queue_cmd(KIND_INSERT, 8'h11, 32'h0000_0001);
    queue_cmd(KIND_INSERT, 8'h22, 32'hFFFF_FFFF);
    queue_cmd(KIND_INSERT, 8'h33, 32'h8000_0000);
    queue_cmd(KIND_INSERT, 8'hAA, 32'h0000_0000);
    queue_cmd(KIND_INSERT, 8'h55, 32'h7FFF_FFFF);
    queue_cmd(KIND_INSERT, 8'hA5, 32'hAAAA_AAAA);
    queue_cmd(KIND_INSERT, 8'h5A, 32'h5555_5555);
    for (int n = 0; n < 9; n++) queue_cmd(KIND_POP, 8'hFF, 32'hFFFF_FFFF);

    queue_random_phase(200, 50);
    queue_random_phase(220, 92);
    queue_random_phase(200, 8);
    queue_random_phase(200, 62);
    queue_random_phase(180, 25);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("huffman_sorted_priority_queue_top verification clean");
    end else begin
      $display("huffman_sorted_priority_queue_top verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("huffman_sorted_priority_queue_top verification failed");
    $finish;
  end

endmodule
